FILE: src/itr_pkg.sv
// Package for the integer-to-radix-text converter: descriptor type, back-end
// state encoding, character constants and sizes shared by all modules.
// No dependencies.
package itr_pkg;

    // Largest number of characters that a conversion may write
    localparam logic [6:0] MAX_CHARS   = 7'd40;
    // Depth of the request queue between front and back
    localparam int         QUEUE_DEPTH = 2;
    // One power of the radix per possible digit of a 32-bit value
    localparam int         POW_DEPTH   = 32;
    localparam int         POW_AW      = $clog2(POW_DEPTH);

    // Radix limits
    localparam logic [5:0] RADIX_MIN = 6'd2;
    localparam logic [5:0] RADIX_MAX = 6'd36;

    // Characters
    localparam logic [7:0] CHAR_MINUS = 8'h2D;  // '-'
    localparam logic [7:0] CHAR_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CHAR_NINE  = 8'h39;  // '9'
    localparam logic [7:0] LETTER_GAP = 8'd39;  // 'a' - '9' - 1

    // Classified request, handed from front to back
    typedef struct packed {
        logic        neg;         // write a leading '-'
        logic [31:0] mag;         // magnitude to print
        logic [5:0]  radix;       // clamped to 2..36
        logic [6:0]  min_digits;  // minimum digit count, 0..64
        logic [6:0]  limit;       // clamped buffer size
    } itr_desc_t;

    localparam int DESC_W = $bits(itr_desc_t);

    // Back-end sequencer states
    typedef enum logic [2:0] {
        B_IDLE,
        B_SIZE,
        B_SIGN,
        B_PAD,
        B_FETCH,
        B_SUB
    } itr_back_state_t;

endpackage

FILE: src/itr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module itr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write one entry, read one entry
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/itr_front.sv
// Front end: takes an input request and classifies it into sign, magnitude,
// clamped radix, minimum digit count and character limit. Uses itr_pkg.
module itr_front
    import itr_pkg::*;
(
    input  logic [31:0] value,
    input  logic [5:0]  radix,
    input  logic [6:0]  width_and_sign,
    input  logic [5:0]  buffer_size,
    output itr_desc_t   desc
);

    logic       sign_mode;
    logic [7:0] neg_width;

    assign sign_mode = width_and_sign[6];
    assign neg_width = 8'd128 - {1'b0, width_and_sign};

    // Classify the request
    always_comb begin
        desc.neg = sign_mode & value[31];
        desc.mag = desc.neg ? (32'd0 - value) : value;

        if (radix < RADIX_MIN) begin
            desc.radix = RADIX_MIN;
        end else if (radix > RADIX_MAX) begin
            desc.radix = RADIX_MAX;
        end else begin
            desc.radix = radix;
        end

        desc.min_digits = sign_mode ? neg_width[6:0] : width_and_sign;

        if ({1'b0, buffer_size} > MAX_CHARS) begin
            desc.limit = MAX_CHARS;
        end else begin
            desc.limit = {1'b0, buffer_size};
        end
    end

endmodule

FILE: src/itr_queue.sv
// Short request queue between front and back ends.
// Uses itr_pkg for the descriptor type.
module itr_queue
    import itr_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  itr_desc_t push_desc,
    output logic      full,
    input  logic      pop,
    output itr_desc_t pop_desc,
    output logic      empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    itr_desc_t     slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_desc = slot_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold request payloads
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

FILE: src/itr_back.sv
// Back end: sizes the number by building radix powers into a small RAM, then
// writes sign, padding and digits (by repeated subtraction) one per output.
// Uses itr_pkg and itr_ram.
module itr_back
    import itr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_empty,
    input  itr_desc_t  q_desc,
    output logic       q_pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] out_char,
    output logic [5:0] position,
    output logic       m_tlast
);

    itr_back_state_t state_reg, state_next;

    logic        neg_reg,   neg_next;
    logic [31:0] mag_reg,   mag_next;
    logic [5:0]  radix_reg, radix_next;
    logic [6:0]  mind_reg,  mind_next;
    logic [6:0]  lim_reg,   lim_next;
    logic [31:0] p_reg,     p_next;
    logic [5:0]  nd_reg,    nd_next;
    logic [5:0]  dl_reg,    dl_next;
    logic [6:0]  pad_reg,   pad_next;
    logic [6:0]  n_reg,     n_next;
    logic [5:0]  dig_reg,   dig_next;

    logic        m_tvalid_reg, m_tvalid_next;
    logic [7:0]  char_reg,     char_next;
    logic [5:0]  pos_reg,      pos_next;
    logic        last_reg,     last_next;

    logic              slot_free;
    logic              emit;
    logic [37:0]       prod;
    logic [7:0]        dig_char;
    logic              wr_en;
    logic [5:0]        nd_dec;
    logic [5:0]        dl_dec;
    logic [31:0]       pow_data;
    logic [6:0]        n_inc;
    logic              digit_last;

    assign slot_free  = !m_tvalid_reg || m_tready;
    assign prod       = 38'(p_reg) * 38'(radix_reg);
    assign nd_dec     = nd_reg - 6'd1;
    assign dl_dec     = dl_reg - 6'd1;
    assign n_inc      = n_reg + 7'd1;
    assign digit_last = !((dl_reg > 6'd1) && (n_inc < lim_reg));

    // Map a digit value to its character
    always_comb begin
        dig_char = CHAR_ZERO + {2'b00, dig_reg};
        if (dig_char > CHAR_NINE) begin
            dig_char = dig_char + LETTER_GAP;
        end
    end

    // Power table, one entry per digit position
    itr_ram #(
        .WIDTH(32),
        .DEPTH(POW_DEPTH)
    ) u_pow_ram (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(nd_dec[POW_AW-1:0]),
        .wr_data(p_reg),
        .rd_addr(dl_dec[POW_AW-1:0]),
        .rd_data(pow_data)
    );

    // Next state and outputs
    always_comb begin
        state_next    = state_reg;
        neg_next      = neg_reg;
        mag_next      = mag_reg;
        radix_next    = radix_reg;
        mind_next     = mind_reg;
        lim_next      = lim_reg;
        p_next        = p_reg;
        nd_next       = nd_reg;
        dl_next       = dl_reg;
        pad_next      = pad_reg;
        n_next        = n_reg;
        dig_next      = dig_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        char_next     = char_reg;
        pos_next      = pos_reg;
        last_next     = last_reg;
        q_pop         = 1'b0;
        wr_en         = 1'b0;
        emit          = 1'b0;

        case (state_reg)
            B_IDLE: begin
                if (!q_empty) begin
                    q_pop      = 1'b1;
                    neg_next   = q_desc.neg;
                    mag_next   = q_desc.mag;
                    radix_next = q_desc.radix;
                    mind_next  = q_desc.min_digits;
                    lim_next   = q_desc.limit;
                    p_next     = 32'd1;
                    nd_next    = 6'd1;
                    n_next     = 7'd0;
                    state_next = B_SIZE;
                end
            end
            B_SIZE: begin
                // Store the current power, grow it while it fits the value
                wr_en = 1'b1;
                if (prod <= {6'b0, mag_reg}) begin
                    p_next  = prod[31:0];
                    nd_next = nd_reg + 6'd1;
                end else begin
                    pad_next   = (mind_reg > {1'b0, nd_reg}) ?
                                 (mind_reg - {1'b0, nd_reg}) : 7'd0;
                    dl_next    = nd_reg;
                    state_next = B_SIGN;
                end
            end
            B_SIGN: begin
                if (!neg_reg) begin
                    state_next = B_PAD;
                end else if (slot_free) begin
                    emit          = 1'b1;
                    m_tvalid_next = 1'b1;
                    char_next     = CHAR_MINUS;
                    pos_next      = n_reg[5:0];
                    last_next     = (lim_reg <= 7'd1);
                    n_next        = n_inc;
                    state_next    = (lim_reg <= 7'd1) ? B_IDLE : B_PAD;
                end
            end
            B_PAD: begin
                if (n_reg >= lim_reg) begin
                    state_next = B_IDLE;
                end else if (pad_reg != 7'd0) begin
                    if (slot_free) begin
                        emit          = 1'b1;
                        m_tvalid_next = 1'b1;
                        char_next     = CHAR_ZERO;
                        pos_next      = n_reg[5:0];
                        last_next     = (n_inc >= lim_reg);
                        n_next        = n_inc;
                        pad_next      = pad_reg - 7'd1;
                    end
                end else begin
                    dig_next   = 6'd0;
                    state_next = B_FETCH;
                end
            end
            B_FETCH: begin
                // Wait for the power of this digit position
                state_next = B_SUB;
            end
            B_SUB: begin
                if (mag_reg >= pow_data) begin
                    mag_next = mag_reg - pow_data;
                    dig_next = dig_reg + 6'd1;
                end else if (slot_free) begin
                    emit          = 1'b1;
                    m_tvalid_next = 1'b1;
                    char_next     = dig_char;
                    pos_next      = n_reg[5:0];
                    last_next     = digit_last;
                    n_next        = n_inc;
                    dl_next       = dl_dec;
                    dig_next      = 6'd0;
                    state_next    = digit_last ? B_IDLE : B_FETCH;
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= B_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Working and output payload registers
    always_ff @(posedge aclk) begin
        neg_reg   <= neg_next;
        mag_reg   <= mag_next;
        radix_reg <= radix_next;
        mind_reg  <= mind_next;
        lim_reg   <= lim_next;
        p_reg     <= p_next;
        nd_reg    <= nd_next;
        dl_reg    <= dl_next;
        pad_reg   <= pad_next;
        n_reg     <= n_next;
        dig_reg   <= dig_next;
        char_reg  <= char_next;
        pos_reg   <= pos_next;
        last_reg  <= last_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign out_char = char_reg;
    assign position = pos_reg;
    assign m_tlast  = last_reg;

    // A digit never reaches the radix
    a_digit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_SUB) |-> (dig_reg < radix_reg))
        else $error("digit counter reached the radix");

    // At most one power per bit of the value
    a_size_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_SIZE) |-> (nd_reg <= 6'd32))
        else $error("power table overran");

    // Digit fetch only once padding is done and digits remain
    a_fetch_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_FETCH) |-> ((pad_reg == 7'd0) && (dl_reg != 6'd0)))
        else $error("digit fetch with padding pending or no digits left");

    // Padding and digits stay inside the buffer
    a_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && (state_reg != B_SIGN)) |-> (n_reg < lim_reg))
        else $error("character written beyond the buffer size");

endmodule

FILE: src/integer_to_radix_text.sv
// Top level of the integer-to-radix-text converter: front end, request queue
// and back end. Uses itr_pkg, itr_front, itr_queue and itr_back.
//
//  channel | ports          | payload (lowest bit first)
//  --------+----------------+-----------------------------------------------
//  request | s_tvalid/ready | tdata: value 32, radix 6, width_and_sign 7,
//          |                |        buffer_size 6, 5 zero bits
//  result  | m_tvalid/ready | tdata: out_char 8, position 6, 2 zero bits;
//          |                | tlast: final character of a conversion
//
// A request is dequeued, then nd radix powers are built into the power RAM
// (nd = natural digit count), the sign stage writes any '-', padding writes
// the pad characters, and each digit of value d takes a power read, d
// subtractions and a write-out on the single subtractor working against the
// power RAM. Two requests may wait in the queue.
// Reset (aresetn low, synchronous) empties the queue and drops any result.
// A stalled result holds the back end; the front keeps taking requests until
// the queue is full.
module integer_to_radix_text
    import itr_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // value, radix, width_and_sign, buffer_size
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // out_char, position
    output logic        m_tlast
);

    itr_desc_t  front_desc;
    itr_desc_t  q_desc;
    logic       q_full;
    logic       q_empty;
    logic       q_pop;
    logic       push;
    logic [7:0] out_char;
    logic [5:0] position;

    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full;

    // Classify incoming requests
    itr_front u_front (
        .value         (s_tdata[31:0]),
        .radix         (s_tdata[37:32]),
        .width_and_sign(s_tdata[44:38]),
        .buffer_size   (s_tdata[50:45]),
        .desc          (front_desc)
    );

    // Decouple front and back
    itr_queue #(
        .DEPTH(QUEUE_DEPTH_P)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_desc(front_desc),
        .full     (q_full),
        .pop      (q_pop),
        .pop_desc (q_desc),
        .empty    (q_empty)
    );

    // Convert and write characters
    itr_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_empty (q_empty),
        .q_desc  (q_desc),
        .q_pop   (q_pop),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .out_char(out_char),
        .position(position),
        .m_tlast (m_tlast)
    );

    assign m_tdata = {2'b00, position, out_char};

endmodule
